### sv/dmc_pkg.sv
// Shared types and constants for the direct-mapped cache tag model.
`timescale 1ns / 1ps
package dmc_pkg;

    localparam int MAX_LINES_DEF = 1024;
    localparam int TAG_W         = 30;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 21;
    localparam int CSIZE_W       = 21;
    localparam int BSIZE_W       = 11;
    localparam int DIV_W         = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd1;

    localparam logic [CSIZE_W-1:0] CSIZE_RESET = 21'd1024;
    localparam logic [BSIZE_W-1:0] BSIZE_RESET = 11'd1;
    localparam logic [31:0]        CNT_MAX     = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        op;
        logic [31:0] address;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_hit_count;
        logic [31:0] read_miss_count;
        logic [31:0] write_hit_count;
        logic [31:0] write_miss_count;
    } t_rsp;

endpackage

### sv/dmc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module dmc_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [dmc_pkg::DIV_W-1:0] i_dividend,
    input  logic [dmc_pkg::DIV_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [dmc_pkg::DIV_W-1:0] o_quot,
    output logic [dmc_pkg::DIV_W-1:0] o_rem
);
    import dmc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_dsr;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DIV_W:0]   trial;
    logic             fits;

    // Trial subtract of the shifted partial remainder
    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign fits  = trial >= {1'b0, r_dsr};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], fits};
            r_rem <= fits ? DIV_W'(trial - {1'b0, r_dsr}) : trial[DIV_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

### sv/direct_mapped_cache_tag_model_core.sv
// Direct-mapped cache tag store with saturating hit and miss counters.
// Each request passes through three divides on the shared radix-2 divider
//   (line count, block number, index/tag), a tag RAM read and an update
//   state; a held result stretches the update state.
// One request is taken at a time: o_stall stays high until its result is registered.
// Reset: synchronous, active low; a clearing pass over all MAX_LINES entries then
//   zeroes the valid bits in the tag RAM before the first request is taken.
`timescale 1ns / 1ps
module direct_mapped_cache_tag_model_core #(
    parameter int MAX_LINES = dmc_pkg::MAX_LINES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  dmc_pkg::t_req                  i_req,
    output logic                           o_stall,
    output logic                           o_valid,
    output dmc_pkg::t_rsp                  o_rsp,
    input  logic                           i_stall,
    input  logic                           i_cfg_we,
    input  logic [dmc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dmc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dmc_pkg::*;

    localparam int LINE_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int LINES_W = $clog2(MAX_LINES + 1);
    localparam int ENTRY_W = TAG_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LINES,
        S_BLOCK,
        S_SPLIT,
        S_READ,
        S_UPDATE
    } t_state;

    t_state               r_state;
    logic [CSIZE_W-1:0]   r_cache_size;
    logic [BSIZE_W-1:0]   r_block_size;
    logic [LINE_W-1:0]    r_clr_idx;
    logic                 r_op;
    logic [31:0]          r_addr;
    logic [LINES_W-1:0]   r_lines;
    logic [LINE_W-1:0]    r_idx;
    logic [TAG_W-1:0]     r_tag;
    logic [ENTRY_W-1:0]   r_rd;
    logic [31:0]          r_rh, r_rm, r_wh, r_wm;
    logic                 r_out_valid;
    t_rsp                 r_out;
    logic                 r_div_start;
    logic [DIV_W-1:0]     r_div_a;
    logic [DIV_W-1:0]     r_div_b;

    logic [ENTRY_W-1:0]   mem [MAX_LINES];
    logic                 mem_we;
    logic [LINE_W-1:0]    mem_addr;
    logic [ENTRY_W-1:0]   mem_wdata;

    logic                 div_done;
    logic [DIV_W-1:0]     div_quot;
    logic [DIV_W-1:0]     div_rem;

    logic [BSIZE_W-1:0]   eff_block;
    logic [LINES_W-1:0]   lines_clamped;
    logic                 hit;
    logic                 out_free;
    logic                 accept;

    assign eff_block = (r_block_size == '0) ? BSIZE_W'(1) : r_block_size;
    assign out_free  = !r_out_valid || !i_stall;
    assign accept    = i_valid && (r_state == S_IDLE);
    assign hit       = r_rd[TAG_W] && (r_rd[TAG_W-1:0] == r_tag);

    // Clamp the line count to 1..MAX_LINES
    always_comb begin
        if (div_quot == '0) begin
            lines_clamped = LINES_W'(1);
        end else if (div_quot > DIV_W'(MAX_LINES)) begin
            lines_clamped = LINES_W'(MAX_LINES);
        end else begin
            lines_clamped = div_quot[LINES_W-1:0];
        end
    end

    dmc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_a),
        .i_divisor  (r_div_b),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_size <= CSIZE_RESET;
            r_block_size <= BSIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CACHE_SIZE: r_cache_size <= i_cfg_data[CSIZE_W-1:0];
                CFG_BLOCK_SIZE: r_block_size <= i_cfg_data[BSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Tag RAM write port: clearing pass or miss fill
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_idx;
        mem_wdata = {1'b1, r_tag};
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_addr  = r_clr_idx;
            mem_wdata = '0;
        end else if (r_state == S_UPDATE && out_free && !hit) begin
            mem_we = 1'b1;
        end
    end

    // Tag RAM
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (r_state == S_READ) begin
            r_rd <= mem[r_idx];
        end
    end

    // Sequencer, counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_rh        <= '0;
            r_rm        <= '0;
            r_wh        <= '0;
            r_wm        <= '0;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == LINE_W'(MAX_LINES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op        <= i_req.op;
                        r_addr      <= i_req.address;
                        r_div_a     <= DIV_W'(r_cache_size);
                        r_div_b     <= DIV_W'(eff_block);
                        r_div_start <= 1'b1;
                        r_state     <= S_LINES;
                    end
                end
                S_LINES: begin
                    if (div_done) begin
                        r_lines     <= lines_clamped;
                        r_div_a     <= {2'b00, r_addr[31:2]};
                        r_div_b     <= DIV_W'(eff_block);
                        r_div_start <= 1'b1;
                        r_state     <= S_BLOCK;
                    end
                end
                S_BLOCK: begin
                    if (div_done) begin
                        r_div_a     <= div_quot;
                        r_div_b     <= DIV_W'(r_lines);
                        r_div_start <= 1'b1;
                        r_state     <= S_SPLIT;
                    end
                end
                S_SPLIT: begin
                    if (div_done) begin
                        r_idx   <= div_rem[LINE_W-1:0];
                        r_tag   <= div_quot[TAG_W-1:0];
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (out_free) begin
                        r_out.hit              <= hit;
                        r_out.read_hit_count   <= r_rh;
                        r_out.read_miss_count  <= r_rm;
                        r_out.write_hit_count  <= r_wh;
                        r_out.write_miss_count <= r_wm;
                        // advance the selected counter, holding at the top
                        if (hit && r_op) begin
                            if (r_wh != CNT_MAX) begin
                                r_wh <= r_wh + 1'b1;
                                r_out.write_hit_count <= r_wh + 1'b1;
                            end
                        end else if (hit) begin
                            if (r_rh != CNT_MAX) begin
                                r_rh <= r_rh + 1'b1;
                                r_out.read_hit_count <= r_rh + 1'b1;
                            end
                        end else if (r_op) begin
                            if (r_wm != CNT_MAX) begin
                                r_wm <= r_wm + 1'b1;
                                r_out.write_miss_count <= r_wm + 1'b1;
                            end
                        end else begin
                            if (r_rm != CNT_MAX) begin
                                r_rm <= r_rm + 1'b1;
                                r_out.read_miss_count <= r_rm + 1'b1;
                            end
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

### bench/direct_mapped_cache_tag_model_core_tb.sv
// Self-checking bench for the direct-mapped cache tag model with its own hit and miss predictor.
`timescale 1ns / 1ps
module direct_mapped_cache_tag_model_core_tb;
    import dmc_pkg::*;

    localparam int LINES     = 1024;
    localparam int IDLE_WAIT = 150;
    localparam int WD_LIMIT  = 8000;
    localparam int HOLD_LEN  = 400;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    t_req                  i_req = '0;
    logic                  o_stall;
    logic                  o_valid;
    t_rsp                  o_rsp;
    logic                  i_stall = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    direct_mapped_cache_tag_model_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_req(i_req), .o_stall(o_stall),
        .o_valid(o_valid), .o_rsp(o_rsp), .i_stall(i_stall),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [CSIZE_W-1:0] pred_cache_size = CSIZE_RESET;
    logic [BSIZE_W-1:0] pred_block_size = BSIZE_RESET;
    logic               line_ok [LINES];
    logic [31:0]        line_tag [LINES];
    logic [31:0]        rd_hits = '0, rd_misses = '0, wr_hits = '0, wr_misses = '0;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   errors = 0;
    int   rsp_seen = 0;
    bit   quiet = 0;
    bit   held_once = 0;
    int   send_gap = 0;
    int   stall_left = 0;
    int   idle_cycles = 0;
    logic [31:0] recent_addr[$];

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == CNT_MAX) ? v : v + 32'd1;
    endfunction

    // Look up the tag store, update it and the counters, queue the response.
    task automatic lookup_access(t_req r);
        int unsigned eb, lines, blk, idx, tag;
        t_rsp rsp;
        eb    = (pred_block_size == 0) ? 1 : pred_block_size;
        lines = pred_cache_size / eb;
        if (lines < 1) lines = 1;
        if (lines > LINES) lines = LINES;
        blk = r.address / (eb * 4);
        idx = blk % lines;
        tag = blk / lines;
        rsp.hit = line_ok[idx] && (line_tag[idx] == tag);
        if (rsp.hit) begin
            if (r.op) wr_hits = sat_inc(wr_hits);
            else      rd_hits = sat_inc(rd_hits);
        end else begin
            if (r.op) wr_misses = sat_inc(wr_misses);
            else      rd_misses = sat_inc(rd_misses);
            line_ok[idx]  = 1'b1;
            line_tag[idx] = tag;
        end
        rsp.read_hit_count   = rd_hits;
        rsp.read_miss_count  = rd_misses;
        rsp.write_hit_count  = wr_hits;
        rsp.write_miss_count = wr_misses;
        expected_rsps.push_back(rsp);
    endtask

    // Drive requests from the pending queue, with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) lookup_access(i_req);
            if (!(i_valid && o_stall)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    if (!quiet && $urandom_range(0, 9) == 0) begin
                        send_gap = $urandom_range(1, 13) - 1;
                        i_valid <= 1'b0;
                    end else begin
                        i_req   <= pending_reqs.pop_front();
                        i_valid <= 1'b1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Check responses and apply back pressure.
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                rsp_seen++;
                if (expected_rsps.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected response, actual %p", $time, o_rsp);
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (o_rsp.hit !== exp_rsp.hit) begin
                        errors++;
                        $display("%0t: hit expected %0d actual %0d",
                                 $time, exp_rsp.hit, o_rsp.hit);
                    end
                    if (o_rsp.read_hit_count !== exp_rsp.read_hit_count) begin
                        errors++;
                        $display("%0t: read_hit_count expected %0d actual %0d",
                                 $time, exp_rsp.read_hit_count, o_rsp.read_hit_count);
                    end
                    if (o_rsp.read_miss_count !== exp_rsp.read_miss_count) begin
                        errors++;
                        $display("%0t: read_miss_count expected %0d actual %0d",
                                 $time, exp_rsp.read_miss_count, o_rsp.read_miss_count);
                    end
                    if (o_rsp.write_hit_count !== exp_rsp.write_hit_count) begin
                        errors++;
                        $display("%0t: write_hit_count expected %0d actual %0d",
                                 $time, exp_rsp.write_hit_count, o_rsp.write_hit_count);
                    end
                    if (o_rsp.write_miss_count !== exp_rsp.write_miss_count) begin
                        errors++;
                        $display("%0t: write_miss_count expected %0d actual %0d",
                                 $time, exp_rsp.write_miss_count, o_rsp.write_miss_count);
                    end
                end
            end
            // one long hold-off so the block backs up into the sender
            if (!held_once && rsp_seen == 150) begin
                held_once = 1;
                stall_left = HOLD_LEN;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles with no accepted request or response.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else if (i_rst_n) idle_cycles++;
        if (idle_cycles >= WD_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || i_valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_CACHE_SIZE) pred_cache_size = data;
        else if (idx == CFG_BLOCK_SIZE) pred_block_size = data[BSIZE_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_req(logic op, logic [31:0] addr);
        t_req r;
        r.op = op;
        r.address = addr;
        pending_reqs.push_back(r);
        recent_addr.push_back(addr);
        if (recent_addr.size() > 16) void'(recent_addr.pop_front());
    endtask

    // Random traffic: mostly local addresses so lines get reused.
    task automatic push_random(int count, int span);
        logic [31:0] base, addr;
        base = $urandom;
        repeat (count) begin
            case ($urandom_range(0, 9))
                0:       addr = $urandom;
                1, 2:    addr = recent_addr[$urandom_range(0, recent_addr.size() - 1)];
                default: addr = base + $urandom_range(0, span);
            endcase
            push_req(1'($urandom_range(0, 1)), addr);
        end
    endtask

    initial begin
        for (int i = 0; i < LINES; i++) begin
            line_ok[i]  = 1'b0;
            line_tag[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: hits within a block, conflicts, address extremes
        push_req(1'b0, 32'h0);
        push_req(1'b1, 32'h0);
        push_req(1'b0, 32'h3);
        push_req(1'b1, 32'h4);
        push_req(1'b0, 32'h1000);
        push_req(1'b0, 32'h0);
        push_req(1'b0, 32'hFFFF_FFFF);
        push_req(1'b1, 32'hFFFF_FFFF);
        push_req(1'b1, 32'h8000_0000);
        push_req(1'b0, 32'h7FFF_FFFF);

        // zero cache size: a single line
        write_reg(CFG_CACHE_SIZE, 21'd0);
        push_req(1'b0, 32'h40);
        push_req(1'b1, 32'h40);
        push_req(1'b0, 32'h44);
        // zero block size counts as one word, five lines
        write_reg(CFG_BLOCK_SIZE, 21'd0);
        write_reg(CFG_CACHE_SIZE, 21'd5);
        push_req(1'b0, 32'h10);
        push_req(1'b1, 32'h10);
        push_req(1'b0, 32'h24);
        // line count saturates
        write_reg(CFG_CACHE_SIZE, 21'h1F_FFFF);
        write_reg(CFG_BLOCK_SIZE, 21'd1);
        push_req(1'b1, 32'hFFFF_FFFC);
        push_req(1'b0, 32'hFFFF_FFFC);
        // block of 1024 words, tiny cache; unknown register indexes are dropped
        write_reg(CFG_CACHE_SIZE, 21'd16);
        write_reg(CFG_BLOCK_SIZE, 21'd1024);
        write_reg(2'd2, 21'h1F_FFFF);
        write_reg(2'd3, 21'h0);
        push_req(1'b0, 32'h0);
        push_req(1'b1, 32'h0FFF);
        push_req(1'b0, 32'hFFFF_F000);

        // random phases over several geometries
        write_reg(CFG_CACHE_SIZE, 21'h10_0000);
        push_random(80, 32'h40000);
        write_reg(CFG_CACHE_SIZE, 21'd64);
        write_reg(CFG_BLOCK_SIZE, 21'd2);
        push_random(90, 2048);
        write_reg(CFG_CACHE_SIZE, 21'd4096);
        write_reg(CFG_BLOCK_SIZE, 21'd4);
        push_random(90, 32768);
        write_reg(CFG_BLOCK_SIZE, 21'h7FF);
        write_reg(CFG_CACHE_SIZE, CFG_DATA_W'($urandom_range(0, 21'h1F_FFFF)));
        push_random(70, 32'h100000);
        write_reg(CFG_CACHE_SIZE, CFG_DATA_W'($urandom_range(1, 300)));
        write_reg(CFG_BLOCK_SIZE, CFG_DATA_W'($urandom_range(0, 8)));
        push_random(90, 1024);
        write_reg(CFG_CACHE_SIZE, 21'd1024);
        write_reg(CFG_BLOCK_SIZE, 21'd1);
        quiet = 1;
        push_random(80, 8192);

        wait_idle();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
